### rtl/core/fdsm_pkg.sv
// Shared types and constants for the frame drop statistics monitor.
// No dependencies; imported by every module of the block.
package fdsm_pkg;

    localparam int unsigned TS_W      = 48;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned PEND_W    = 16;
    localparam int unsigned JANK_W    = 16;
    localparam int unsigned GOOD_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 264;

    localparam logic [JANK_W-1:0] JANK_RST = 16'd50;
    localparam logic [GOOD_W-1:0] GOOD_RST = 8'd1;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JANK_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_RUN       = 1'b1;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_VSYNC = 2'd2,
        KIND_SWAP  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TS_W-1:0]    timestamp_ms;
        logic signed [31:0] view_id;
    } t_event;

    typedef struct packed {
        logic               loss_flag;
        logic               jank_flag;
        logic [CNT_W-1:0]   longest_miss_run;
        logic [CNT_W-1:0]   longest_gap;
        logic [CNT_W-1:0]   missed_count;
        logic [CNT_W-1:0]   frame_count;
        logic [TS_W-1:0]    window_length;
        logic [TS_W-1:0]    window_start;
        logic signed [31:0] out_view_id;
    } t_summary;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/core/fdsm_core.sv
// Event input register, window statistics state and configuration registers.
// Depends on fdsm_pkg.
module fdsm_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_evt_valid,
    output logic                           o_evt_ready,
    input  fdsm_pkg::t_event               i_evt,
    input  logic                           i_cfg_we,
    input  logic [fdsm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fdsm_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                           i_res_ready,
    output logic                           o_res_push,
    output fdsm_pkg::t_summary             o_res
);
    import fdsm_pkg::*;

    logic              r_in_valid;
    t_event            r_in;

    logic [JANK_W-1:0] r_jank_thr;
    logic [GOOD_W-1:0] r_good_thr;

    logic              r_monitoring,     n_monitoring;
    logic              r_saw_first_swap, n_saw_first_swap;
    logic [TS_W-1:0]   r_start_stamp,    n_start_stamp;
    logic [31:0]       r_current_view,   n_current_view;
    logic [CNT_W-1:0]  r_frames_total,   n_frames_total;
    logic [CNT_W-1:0]  r_frames_missed,  n_frames_missed;
    logic [CNT_W-1:0]  r_miss_run,       n_miss_run;
    logic [CNT_W-1:0]  r_max_miss_run,   n_max_miss_run;
    logic [CNT_W-1:0]  r_good_run,       n_good_run;
    logic [TS_W-1:0]   r_last_swap,      n_last_swap;
    logic              r_have_last_swap, n_have_last_swap;
    logic [CNT_W-1:0]  r_max_gap,        n_max_gap;
    logic [PEND_W-1:0] r_pending,        n_pending;

    logic              s_need_out;
    logic              s_fire;
    logic [TS_W-1:0]   s_gap;
    logic [CNT_W-1:0]  s_gap_sat;
    logic [CNT_W-1:0]  s_run;
    logic [CNT_W-1:0]  s_good;

    assign s_need_out  = r_in_valid && (r_in.kind == KIND_STOP) && r_monitoring;
    assign s_fire      = r_in_valid && (!s_need_out || i_res_ready);
    assign o_evt_ready = !r_in_valid || s_fire;
    assign o_res_push  = s_need_out && s_fire;

    assign s_gap     = r_in.timestamp_ms - r_last_swap;
    assign s_gap_sat = (s_gap[TS_W-1:CNT_W] != '0) ? CNT_MAX : s_gap[CNT_W-1:0];

    always_comb begin
        o_res.out_view_id      = r_current_view;
        o_res.window_start     = r_start_stamp;
        o_res.window_length    = r_in.timestamp_ms - r_start_stamp;
        o_res.frame_count      = r_frames_total;
        o_res.missed_count     = r_frames_missed;
        o_res.longest_gap      = r_max_gap;
        o_res.longest_miss_run = r_max_miss_run;
        o_res.jank_flag        = r_max_gap >= {{(CNT_W-JANK_W){1'b0}}, r_jank_thr};
        o_res.loss_flag        = r_frames_missed != '0;
    end

    always_comb begin
        n_monitoring     = r_monitoring;
        n_saw_first_swap = r_saw_first_swap;
        n_start_stamp    = r_start_stamp;
        n_current_view   = r_current_view;
        n_frames_total   = r_frames_total;
        n_frames_missed  = r_frames_missed;
        n_miss_run       = r_miss_run;
        n_max_miss_run   = r_max_miss_run;
        n_good_run       = r_good_run;
        n_last_swap      = r_last_swap;
        n_have_last_swap = r_have_last_swap;
        n_max_gap        = r_max_gap;
        n_pending        = r_pending;
        s_run            = r_miss_run;
        s_good           = r_good_run;

        unique case (r_in.kind)
            KIND_START: begin
                n_current_view = r_in.view_id;
                if (!r_monitoring) begin
                    n_monitoring  = 1'b1;
                    n_start_stamp = r_in.timestamp_ms;
                end
            end
            KIND_STOP: begin
                if (r_monitoring) begin
                    n_monitoring     = 1'b0;
                    n_saw_first_swap = 1'b0;
                    n_start_stamp    = '0;
                    n_frames_total   = '0;
                    n_frames_missed  = '0;
                    n_miss_run       = '0;
                    n_max_miss_run   = '0;
                    n_good_run       = '0;
                    n_last_swap      = '0;
                    n_have_last_swap = 1'b0;
                    n_max_gap        = '0;
                    n_pending        = '0;
                end
            end
            KIND_VSYNC: begin
                if (r_monitoring) begin
                    n_frames_total = sat_inc(r_frames_total);
                    if (r_saw_first_swap) begin
                        if (r_pending == '0) begin
                            n_frames_missed = sat_inc(r_frames_missed);
                            s_run           = sat_inc(r_miss_run);
                            // a long good run survives a single miss
                            if (r_good_run <= {{(CNT_W-GOOD_W){1'b0}}, r_good_thr})
                                n_good_run = '0;
                        end else begin
                            s_good     = sat_inc(r_good_run);
                            n_good_run = s_good;
                            if (s_good > {{(CNT_W-GOOD_W){1'b0}}, r_good_thr})
                                s_run = '0;
                            n_pending = r_pending - 1'b1;
                        end
                        n_miss_run = s_run;
                        if (s_run > r_max_miss_run)
                            n_max_miss_run = s_run;
                    end
                end
            end
            KIND_SWAP: begin
                if (r_monitoring) begin
                    n_saw_first_swap = 1'b1;
                    if (r_pending != PEND_MAX)
                        n_pending = r_pending + 1'b1;
                    // backwards time counts as no gap
                    if (r_have_last_swap && (r_in.timestamp_ms > r_last_swap)
                        && (s_gap_sat > r_max_gap))
                        n_max_gap = s_gap_sat;
                    n_have_last_swap = 1'b1;
                    n_last_swap      = r_in.timestamp_ms;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_evt_ready) begin
            r_in_valid <= i_evt_valid;
        end
        if (o_evt_ready && i_evt_valid) begin
            r_in <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jank_thr <= JANK_RST;
            r_good_thr <= GOOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_JANK_THRESHOLD: r_jank_thr <= i_cfg_wdata[JANK_W-1:0];
                CFG_GOOD_RUN:       r_good_thr <= i_cfg_wdata[GOOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_monitoring     <= 1'b0;
            r_saw_first_swap <= 1'b0;
            r_start_stamp    <= '0;
            r_current_view   <= '0;
            r_frames_total   <= '0;
            r_frames_missed  <= '0;
            r_miss_run       <= '0;
            r_max_miss_run   <= '0;
            r_good_run       <= '0;
            r_last_swap      <= '0;
            r_have_last_swap <= 1'b0;
            r_max_gap        <= '0;
            r_pending        <= '0;
        end else if (s_fire) begin
            r_monitoring     <= n_monitoring;
            r_saw_first_swap <= n_saw_first_swap;
            r_start_stamp    <= n_start_stamp;
            r_current_view   <= n_current_view;
            r_frames_total   <= n_frames_total;
            r_frames_missed  <= n_frames_missed;
            r_miss_run       <= n_miss_run;
            r_max_miss_run   <= n_max_miss_run;
            r_good_run       <= n_good_run;
            r_last_swap      <= n_last_swap;
            r_have_last_swap <= n_have_last_swap;
            r_max_gap        <= n_max_gap;
            r_pending        <= n_pending;
        end
    end

endmodule

### rtl/core/fdsm_out_skid.sv
// Output register with a skid word for the summary stream.
// Depends on fdsm_pkg.
module fdsm_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fdsm_pkg::t_summary i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output fdsm_pkg::t_summary o_data
);
    import fdsm_pkg::*;

    logic     r_main_valid;
    logic     r_skid_valid;
    t_summary r_main;
    t_summary r_skid;

    // ready is registered: nothing from the downstream ready reaches upstream
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

### rtl/core/frame_drop_statistics_monitor_top.sv
// Top level of the frame drop statistics monitor: stream ports and packing.
// Depends on fdsm_pkg, fdsm_core and fdsm_out_skid.
//
// Takes start, stop, vsync and buffer-swap events and accepts one event word
// per clock when the output side keeps up. An event is registered on entry and
// the window statistics update from that register; a stop event in a monitoring
// window puts one summary word into the output register, then the window state
// clears. Only stop events that produce a summary can stall the input, and only
// when both output words (register and skid) are held by downstream
// backpressure. Configuration writes take effect on the next clock and are
// meant for idle periods. Counters saturate.
module frame_drop_statistics_monitor_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [47:0] timestamp_ms, [79:48] view_id
    input  logic [fdsm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] out_view_id, [79:32] window_start, [127:80] window_length,
    // [159:128] frame_count, [191:160] missed_count, [223:192] longest_gap,
    // [255:224] longest_miss_run, [256] jank_flag, [257] loss_flag, rest zero
    output logic [fdsm_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [fdsm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fdsm_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);
    import fdsm_pkg::*;

    t_event   s_evt;
    t_summary s_res;
    t_summary s_out;
    logic     s_res_push;
    logic     s_res_ready;

    assign s_evt.kind         = t_kind'(i_s_axis_tuser);
    assign s_evt.timestamp_ms = i_s_axis_tdata[47:0];
    assign s_evt.view_id      = i_s_axis_tdata[79:48];

    fdsm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_s_axis_tvalid),
        .o_evt_ready (o_s_axis_tready),
        .i_evt       (s_evt),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_res_ready (s_res_ready),
        .o_res_push  (s_res_push),
        .o_res       (s_res)
    );

    fdsm_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res),
        .o_ready (s_res_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (s_out)
    );

    assign o_m_axis_tdata = {6'd0, s_out.loss_flag, s_out.jank_flag,
                             s_out.longest_miss_run, s_out.longest_gap,
                             s_out.missed_count, s_out.frame_count,
                             s_out.window_length, s_out.window_start,
                             s_out.out_view_id};

endmodule

### dv/tb_frame_drop_statistics_monitor_top.sv
// Self-checking testbench for frame_drop_statistics_monitor_top: directed and random event
// streams with random stalls on both stream sides, checked against a cycle-free window model.
// Depends on fdsm_pkg and the block's RTL only.
module tb_frame_drop_statistics_monitor_top;
    import fdsm_pkg::*;

    localparam int SUM_W        = $bits(t_summary);
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_wdata = '0;

    frame_drop_statistics_monitor_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // window model state
    logic [JANK_W-1:0]  jank_ms   = JANK_RST;
    logic [GOOD_W-1:0]  good_need = GOOD_RST;
    bit                 win_open;
    bit                 swap_seen;
    logic [TS_W-1:0]    win_start;
    logic [31:0]        win_view;
    logic [CNT_W-1:0]   vsync_total;
    logic [CNT_W-1:0]   vsync_missed;
    logic [CNT_W-1:0]   miss_streak;
    logic [CNT_W-1:0]   miss_streak_max;
    logic [CNT_W-1:0]   good_streak;
    logic [TS_W-1:0]    prev_swap_ts;
    bit                 prev_swap_valid;
    logic [CNT_W-1:0]   gap_max;
    logic [PEND_W-1:0]  buffers_queued;

    t_event   event_backlog[$];
    t_summary pending_summaries[$];
    t_event   offered;
    t_summary next_summary;
    t_summary seen_sum;
    t_summary want_sum;

    int  items_pushed   = 0;
    int  items_accepted = 0;
    int  mismatches     = 0;
    int  idle_cycles    = 0;
    int  src_odds       = 20;
    int  sink_odds      = 20;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    int  hold_left      = 0;
    bit  hold_request   = 1'b0;

    function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic void close_window();
        win_open        = 1'b0;
        swap_seen       = 1'b0;
        win_start       = '0;
        vsync_total     = '0;
        vsync_missed    = '0;
        miss_streak     = '0;
        miss_streak_max = '0;
        good_streak     = '0;
        prev_swap_ts    = '0;
        prev_swap_valid = 1'b0;
        gap_max         = '0;
        buffers_queued  = '0;
    endfunction

    // Applies one event to the window model; returns 1 when it closes a window with a summary.
    function automatic bit advance_window(input t_event ev, output t_summary summary);
        logic [TS_W-1:0]  span;
        logic [CNT_W-1:0] clipped;
        summary = '0;
        case (ev.kind)
            KIND_START: begin
                win_view = ev.view_id;
                if (!win_open) begin
                    win_open  = 1'b1;
                    win_start = ev.timestamp_ms;
                end
                return 1'b0;
            end
            KIND_STOP: begin
                if (!win_open)
                    return 1'b0;
                summary.out_view_id      = win_view;
                summary.window_start     = win_start;
                summary.window_length    = ev.timestamp_ms - win_start;
                summary.frame_count      = vsync_total;
                summary.missed_count     = vsync_missed;
                summary.longest_gap      = gap_max;
                summary.longest_miss_run = miss_streak_max;
                summary.jank_flag        = (gap_max >= {{(CNT_W-JANK_W){1'b0}}, jank_ms});
                summary.loss_flag        = (vsync_missed != '0);
                close_window();
                return 1'b1;
            end
            KIND_VSYNC: begin
                if (!win_open)
                    return 1'b0;
                vsync_total = bump32(vsync_total);
                // no miss accounting until the first swap of the window
                if (swap_seen) begin
                    if (buffers_queued == '0) begin
                        vsync_missed = bump32(vsync_missed);
                        miss_streak  = bump32(miss_streak);
                        if (good_streak <= {{(CNT_W-GOOD_W){1'b0}}, good_need})
                            good_streak = '0;
                    end else begin
                        good_streak = bump32(good_streak);
                        if (good_streak > {{(CNT_W-GOOD_W){1'b0}}, good_need})
                            miss_streak = '0;
                        buffers_queued = buffers_queued - 1'b1;
                    end
                    if (miss_streak > miss_streak_max)
                        miss_streak_max = miss_streak;
                end
                return 1'b0;
            end
            default: begin
                if (!win_open)
                    return 1'b0;
                swap_seen = 1'b1;
                if (buffers_queued != {PEND_W{1'b1}})
                    buffers_queued = buffers_queued + 1'b1;
                if (prev_swap_valid && ev.timestamp_ms > prev_swap_ts) begin
                    span    = ev.timestamp_ms - prev_swap_ts;
                    clipped = (span > {{(TS_W-CNT_W){1'b0}}, {CNT_W{1'b1}}}) ?
                              {CNT_W{1'b1}} : span[CNT_W-1:0];
                    if (clipped > gap_max)
                        gap_max = clipped;
                end
                prev_swap_valid = 1'b1;
                prev_swap_ts    = ev.timestamp_ms;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %0s: got %h expected %h", what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // source side: one word per handshake, random idle bursts between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_accepted++;
                if (advance_window(offered, next_summary))
                    pending_summaries.push_back(next_summary);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (src_odds != 0 && $urandom_range(0, 99) < src_odds) begin
                    src_gap = $urandom_range(0, 17);
                    i_s_axis_tvalid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    offered = event_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {offered.view_id, offered.timestamp_ms};
                    i_s_axis_tuser  <= offered.kind;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side ready: random stall bursts plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else if (sink_odds != 0 && $urandom_range(0, 99) < sink_odds) begin
                sink_gap = $urandom_range(0, 17);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_sum = t_summary'(o_m_axis_tdata[SUM_W-1:0]);
            check_field("tdata padding", 64'(o_m_axis_tdata[M_TDATA_W-1:SUM_W]), '0);
            if (pending_summaries.size() == 0) begin
                report_mismatch("summary word with none expected", '0, '0);
            end else begin
                want_sum = pending_summaries.pop_front();
                check_field("out_view_id", 64'(seen_sum.out_view_id),
                            64'(want_sum.out_view_id));
                check_field("window_start", 64'(seen_sum.window_start),
                            64'(want_sum.window_start));
                check_field("window_length", 64'(seen_sum.window_length),
                            64'(want_sum.window_length));
                check_field("frame_count", 64'(seen_sum.frame_count),
                            64'(want_sum.frame_count));
                check_field("missed_count", 64'(seen_sum.missed_count),
                            64'(want_sum.missed_count));
                check_field("longest_gap", 64'(seen_sum.longest_gap),
                            64'(want_sum.longest_gap));
                check_field("longest_miss_run", 64'(seen_sum.longest_miss_run),
                            64'(want_sum.longest_miss_run));
                check_field("jank_flag", 64'(seen_sum.jank_flag), 64'(want_sum.jank_flag));
                check_field("loss_flag", 64'(seen_sum.loss_flag), 64'(want_sum.loss_flag));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL frame_drop_statistics_monitor_top");
        $finish;
    end

    function automatic logic [TS_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TS_W-1:0];
    endfunction

    task automatic push_event(input t_kind kind, input logic [TS_W-1:0] ts,
                              input logic [31:0] view);
        t_event ev;
        ev.kind         = kind;
        ev.timestamp_ms = ts;
        ev.view_id      = view;
        event_backlog.push_back(ev);
        items_pushed++;
    endtask

    // one monitoring window: start, a body of vsyncs and swaps, stop
    task automatic push_window(input int n_body);
        logic [TS_W-1:0] ts;
        int swap_pct;
        int roll;
        ts = rand48();
        swap_pct = $urandom_range(25, 70);
        push_event(KIND_START, ts, $urandom);
        repeat (n_body) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                ts = rand48();
            else if (roll < 8)
                ts = ts - $urandom_range(1, 40);
            else
                ts = ts + $urandom_range(0, 90);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                push_event(KIND_START, ts, $urandom);
            else if (roll < 4 + swap_pct)
                push_event(KIND_SWAP, ts, $urandom);
            else
                push_event(KIND_VSYNC, ts, $urandom);
        end
        push_event(KIND_STOP, ts + $urandom_range(0, 500), $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_JANK_THRESHOLD)
            jank_ms = value[JANK_W-1:0];
        else
            good_need = value[GOOD_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every word to be taken and every summary to come back, then let the pipe drain
    task automatic settle();
        while (items_accepted != items_pushed || pending_summaries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    initial begin
        int phase_goal;
        int body;
        logic [TS_W-1:0] ts;
        close_window();
        win_view = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // events outside a window are dropped
        push_event(KIND_STOP,  48'h5, 32'h0);
        push_event(KIND_VSYNC, 48'h6, 32'h0);
        push_event(KIND_SWAP,  48'h7, 32'h0);
        // second start only swaps the view
        push_event(KIND_START, 48'h100, 32'h7FFF_FFFF);
        push_event(KIND_START, 48'h200, 32'h8000_0000);
        push_event(KIND_VSYNC, 48'h210, 32'h0);
        push_event(KIND_SWAP,  48'h300, 32'h0);
        push_event(KIND_SWAP,  48'h310, 32'h0);
        push_event(KIND_SWAP,  48'h320, 32'h0);
        repeat (3) push_event(KIND_VSYNC, 48'h330, 32'h0);
        // misses after a good run longer than the threshold
        repeat (2) push_event(KIND_VSYNC, 48'h340, 32'h0);
        push_event(KIND_SWAP,  48'h100, 32'h0);
        push_event(KIND_SWAP,  48'hFFFF_FFFF_FFFF, 32'h0);
        push_event(KIND_STOP,  48'h50, 32'h0);
        push_event(KIND_START, 48'hFFFF_FFFF_FFFF, 32'h0);
        push_event(KIND_SWAP,  48'h0, 32'h0);
        push_event(KIND_SWAP,  48'd49, 32'h0);
        push_event(KIND_VSYNC, 48'd60, 32'h0);
        push_event(KIND_STOP,  48'h40, 32'hFFFF_FFFF);
        push_event(KIND_START, 48'h1000, 32'hFFFF_FFFF);
        push_event(KIND_SWAP,  48'h1000, 32'h0);
        push_event(KIND_SWAP,  48'h1032, 32'h0);
        push_event(KIND_STOP,  48'h2000, 32'h0);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_JANK_THRESHOLD, 16'h0);
                    write_reg(CFG_GOOD_RUN, 16'h0);
                end
                1: begin
                    write_reg(CFG_JANK_THRESHOLD, 16'hFFFF);
                    write_reg(CFG_GOOD_RUN, 16'hFFFF);
                end
                3: begin
                    write_reg(CFG_JANK_THRESHOLD, 16'd1);
                    write_reg(CFG_GOOD_RUN, 16'd2);
                end
                5: begin
                    write_reg(CFG_JANK_THRESHOLD, JANK_RST);
                    write_reg(CFG_GOOD_RUN, {8'h00, GOOD_RST});
                end
                default: begin
                    write_reg(CFG_JANK_THRESHOLD, 16'($urandom_range(0, 120)));
                    // upper byte is junk for the 8-bit register
                    write_reg(CFG_GOOD_RUN, {8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 4))});
                end
            endcase
            case (phase % 3)
                0: begin
                    src_odds  = 0;
                    sink_odds = 30;
                end
                1: begin
                    src_odds  = 10;
                    sink_odds = 0;
                end
                default: begin
                    src_odds  = 35;
                    sink_odds = 35;
                end
            endcase
            if (phase == PHASES - 1) begin
                src_odds  = 0;
                sink_odds = 0;
            end
            if (phase == 1) begin
                // sink holds off while back-to-back short windows keep arriving
                src_odds     = 0;
                hold_request = 1'b1;
                repeat (40) begin
                    ts = rand48();
                    push_event(KIND_START, ts, $urandom);
                    if ($urandom_range(0, 1) == 1)
                        push_event(KIND_SWAP, ts + 1, $urandom);
                    push_event(KIND_STOP, ts + $urandom_range(0, 9), $urandom);
                end
            end
            phase_goal = items_pushed + 145;
            while (items_pushed < phase_goal) begin
                body = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14)
                                                    : $urandom_range(15, 60);
                push_window(body);
                repeat ($urandom_range(0, 1))
                    push_event(t_kind'($urandom_range(0, 3)), rand48(), $urandom);
            end
            settle();
        end

        if (mismatches == 0)
            $display("PASS frame_drop_statistics_monitor_top");
        else
            $display("FAIL frame_drop_statistics_monitor_top");
        $finish;
    end

endmodule
